// ===== rtl/rmq_pkg.sv =====
// Shared types and widths for the rotation matrix to quaternion pipeline.
package rmq_pkg;

  localparam int NW = 36;   // numerator and sum width, signed
  localparam int VW = 34;   // radicand width before scaling
  localparam int RW = 64;   // scaled radicand width
  localparam int QW = 32;   // root and quotient width
  localparam int DW = 68;   // dividend width
  localparam int SQ_STAGES = 32;
  localparam int DV_STAGES = 32;

  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X     = 2'd1;
  localparam logic [1:0] BR_Y     = 2'd2;
  localparam logic [1:0] BR_Z     = 2'd3;

  typedef struct packed {
    logic signed [NW-1:0] n0;
    logic signed [NW-1:0] n1;
    logic signed [NW-1:0] n2;
    logic [1:0]           branch;
    logic                 degen;
  } meta_t;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] q;
    logic          ovf;
    logic          neg;
  } lane_t;

endpackage

// ===== rtl/rmq_pre.sv =====
// Input stage: trace test, branch choice, radicand and numerators.
module rmq_pre #(
  parameter int FRAC_BITS = 30
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic signed [31:0]         m00, m01, m02, m10, m11, m12, m20, m21, m22,
  output logic                       vld,
  output logic [rmq_pkg::VW-1:0]     v,
  output rmq_pkg::meta_t             meta
);
  import rmq_pkg::*;

  logic signed [NW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22, one, t, u;
  logic [1:0]           br;
  logic                 dg;
  logic [VW-1:0]        v_next;
  meta_t                meta_next;

  always_comb begin
    a00 = NW'(m00); a01 = NW'(m01); a02 = NW'(m02);
    a10 = NW'(m10); a11 = NW'(m11); a12 = NW'(m12);
    a20 = NW'(m20); a21 = NW'(m21); a22 = NW'(m22);
    one = NW'(1) <<< FRAC_BITS;
    t = a00 + a11 + a22 + one;
    if (m00 > m11 && m00 > m22) begin
      u = one + a00 - a11 - a22;
    end else if (m11 > m22) begin
      u = one + a11 - a00 - a22;
    end else begin
      u = one + a22 - a00 - a11;
    end
    dg = 1'b0;
    if (t > 0) begin
      br = BR_TRACE;
      v_next = t[VW-1:0];
      meta_next.n0 = a21 - a12;
      meta_next.n1 = a02 - a20;
      meta_next.n2 = a10 - a01;
    end else begin
      if (m00 > m11 && m00 > m22) begin
        br = BR_X;
        meta_next.n0 = a01 + a10;
        meta_next.n1 = a02 + a20;
        meta_next.n2 = a21 - a12;
      end else if (m11 > m22) begin
        br = BR_Y;
        meta_next.n0 = a01 + a10;
        meta_next.n1 = a12 + a21;
        meta_next.n2 = a02 - a20;
      end else begin
        br = BR_Z;
        meta_next.n0 = a02 + a20;
        meta_next.n1 = a12 + a21;
        meta_next.n2 = a10 - a01;
      end
      if (u <= 0) begin
        dg = 1'b1;
        v_next = VW'(1);
      end else begin
        v_next = u[VW-1:0];
      end
    end
    meta_next.branch = br;
    meta_next.degen  = dg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v    <= v_next;
      meta <= meta_next;
    end
  end

endmodule

// ===== rtl/rmq_sqrt.sv =====
// Square root pipeline, one root bit per stage.
module rmq_sqrt #(
  parameter int FRAC_BITS = 30
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic [rmq_pkg::VW-1:0] v,
  input  rmq_pkg::meta_t         in_meta,
  output logic                   out_vld,
  output logic [rmq_pkg::QW-1:0] root,
  output rmq_pkg::meta_t         out_meta
);
  import rmq_pkg::*;

  logic [RW-1:0] rem  [0:SQ_STAGES];
  logic [QW-1:0] rt   [0:SQ_STAGES];
  meta_t         mt   [0:SQ_STAGES];
  logic          vl   [0:SQ_STAGES];

  assign rem[0] = RW'(v) << FRAC_BITS;
  assign rt[0]  = '0;
  assign mt[0]  = in_meta;
  assign vl[0]  = in_vld;

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
    localparam int B = SQ_STAGES - 1 - s;
    logic [RW-1:0] trial;
    assign trial = (RW'(rt[s]) << (B + 1)) + (RW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[s+1] <= 1'b0;
      end else if (en) begin
        vl[s+1] <= vl[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mt[s+1] <= mt[s];
        if (rem[s] >= trial) begin
          rem[s+1] <= rem[s] - trial;
          rt[s+1]  <= rt[s] | (QW'(1) << B);
        end else begin
          rem[s+1] <= rem[s];
          rt[s+1]  <= rt[s];
        end
      end
    end
  end

  assign out_vld  = vl[SQ_STAGES];
  assign root     = rt[SQ_STAGES];
  assign out_meta = mt[SQ_STAGES];

endmodule

// ===== rtl/rmq_div.sv =====
// Three-lane rounding divider pipeline, one quotient bit per stage, saturated.
module rmq_div #(
  parameter int FRAC_BITS = 30
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [rmq_pkg::QW-1:0]        in_root,
  input  rmq_pkg::meta_t                in_meta,
  output logic                          out_vld,
  output logic [rmq_pkg::QW-1:0]        out_root,
  output rmq_pkg::meta_t                out_meta,
  output logic signed [rmq_pkg::QW-1:0] q0,
  output logic signed [rmq_pkg::QW-1:0] q1,
  output logic signed [rmq_pkg::QW-1:0] q2
);
  import rmq_pkg::*;

  localparam int ST = DV_STAGES + 1;

  lane_t         ln [0:2][0:ST];
  logic [QW-1:0] rt [0:ST];
  meta_t         mt [0:ST];
  logic          vl [0:ST];
  logic [DW-1:0] dv [0:ST];

  logic signed [NW-1:0] num [0:2];
  logic [QW-1:0]        qs  [0:2];
  logic [QW-1:0]        one;

  assign num[0] = in_meta.n0;
  assign num[1] = in_meta.n1;
  assign num[2] = in_meta.n2;
  assign one    = QW'(1) << FRAC_BITS;

  assign rt[0] = in_root;
  assign mt[0] = in_meta;
  assign vl[0] = in_vld;
  assign dv[0] = DW'(in_root) << 1;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [NW-1:0] mag;
    logic [DW-1:0] nd;
    assign mag = num[l][NW-1] ? NW'(-num[l]) : NW'(num[l]);
    assign nd  = (DW'(mag) << FRAC_BITS) + DW'(in_root);
    assign ln[l][0].rem = nd;
    assign ln[l][0].q   = '0;
    assign ln[l][0].ovf = nd >= (dv[0] << QW);
    assign ln[l][0].neg = num[l][NW-1];
  end

  for (genvar s = 0; s < ST; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vl[s+1] <= 1'b0;
      end else if (en) begin
        vl[s+1] <= vl[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt[s+1] <= rt[s];
        mt[s+1] <= mt[s];
        dv[s+1] <= dv[s];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_ln
      if (s == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (en) begin
            ln[l][s+1] <= ln[l][s];
          end
        end
      end else begin : g_bit
        localparam int B = ST - 1 - s;
        logic [DW-1:0] dsh;
        assign dsh = dv[s] << B;
        always_ff @(posedge clk) begin
          if (en) begin
            ln[l][s+1].ovf <= ln[l][s].ovf;
            ln[l][s+1].neg <= ln[l][s].neg;
            if (!ln[l][s].ovf && ln[l][s].rem >= dsh) begin
              ln[l][s+1].rem <= ln[l][s].rem - dsh;
              ln[l][s+1].q   <= ln[l][s].q | (QW'(1) << B);
            end else begin
              ln[l][s+1].rem <= ln[l][s].rem;
              ln[l][s+1].q   <= ln[l][s].q;
            end
          end
        end
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_out
    logic [QW-1:0] m;
    assign m = (ln[l][ST].ovf || ln[l][ST].q > one) ? one : ln[l][ST].q;
    assign qs[l] = ln[l][ST].neg ? QW'(-m) : m;
  end

  assign q0       = qs[0];
  assign q1       = qs[1];
  assign q2       = qs[2];
  assign out_vld  = vl[ST];
  assign out_root = rt[ST];
  assign out_meta = mt[ST];

endmodule

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// Top level: rotation matrix to unit quaternion pipeline.
//
// Input channel: in_valid / in_stall with the nine matrix elements m00..m22,
// signed fixed point with FRAC_BITS fraction bits. Output channel:
// out_valid / out_stall with qx, qy, qz, qw, branch_used and degenerate.
// A beat is taken at an edge where valid is high and stall is low.
// The stages are one input stage, 32 square root stages (one root bit
// each), one dividend stage, 32 divider stages (one quotient bit each,
// three lanes side by side) and the output register. Throughput is one
// matrix per cycle while not stalled. All stages move together: when the
// output register holds a beat and out_stall is high, the whole pipeline
// holds and in_stall goes high; nothing is lost or repeated. Reset clears
// every stage valid bit, so the pipeline comes up empty and ready.
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = 30
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] qx, qy, qz, qw,
  output logic [1:0]         branch_used,
  output logic               degenerate
);
  import rmq_pkg::*;

  logic          en;
  logic          p_vld, s_vld, d_vld;
  logic [VW-1:0] p_v;
  meta_t         p_meta, s_meta, d_meta;
  logic [QW-1:0] s_root, d_root, one, half;
  logic [QW:0]   hsum;
  logic signed [QW-1:0] q0, q1, q2;
  logic signed [31:0] qx_next, qy_next, qz_next, qw_next;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  rmq_pre #(.FRAC_BITS(FRAC_BITS)) u_pre (
    .clk, .rst, .en, .in_valid,
    .m00, .m01, .m02, .m10, .m11, .m12, .m20, .m21, .m22,
    .vld(p_vld), .v(p_v), .meta(p_meta)
  );

  rmq_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk, .rst, .en, .in_vld(p_vld), .v(p_v), .in_meta(p_meta),
    .out_vld(s_vld), .root(s_root), .out_meta(s_meta)
  );

  rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst, .en, .in_vld(s_vld), .in_root(s_root), .in_meta(s_meta),
    .out_vld(d_vld), .out_root(d_root), .out_meta(d_meta),
    .q0, .q1, .q2
  );

  always_comb begin
    one  = QW'(1) << FRAC_BITS;
    hsum = ({1'b0, d_root} + (QW+1)'(1)) >> 1;
    half = (hsum > (QW+1)'(one)) ? one : hsum[QW-1:0];
    qx_next = q0; qy_next = q1; qz_next = q2; qw_next = half;
    case (d_meta.branch)
      BR_TRACE: begin
        qx_next = q0; qy_next = q1; qz_next = q2; qw_next = half;
      end
      BR_X: begin
        qx_next = half; qy_next = q0; qz_next = q1; qw_next = q2;
      end
      BR_Y: begin
        qx_next = q0; qy_next = half; qz_next = q1; qw_next = q2;
      end
      BR_Z: begin
        qx_next = q0; qy_next = q1; qz_next = half; qw_next = q2;
      end
      default: begin
        qx_next = q0; qy_next = q1; qz_next = q2; qw_next = half;
      end
    endcase
    if (d_meta.degen) begin
      qx_next = '0; qy_next = '0; qz_next = '0; qw_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qx          <= qx_next;
      qy          <= qy_next;
      qz          <= qz_next;
      qw          <= qw_next;
      branch_used <= d_meta.branch;
      degenerate  <= d_meta.degen;
    end
  end

endmodule
